/* rtl/poi_pkg.sv */
// ----------------------------------------------------------------------------
// poi_pkg
// Shared types, constants and tables of the planar odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

  // default number of cordic micro-rotations
  localparam int CORDIC_STEPS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 1'b1;
  localparam logic signed [15:0] GAIN_RESET = 16'sd4096;

  // constant divider sizes: five 12-bit digits cover the 58-bit numerator
  localparam int DIV_NUM_W = 58;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_DIG_W = 12;
  localparam int DIV_DIG_N = 5;
  localparam int DIV_CNT_W = 3;

  // divisors and rounding offsets
  localparam logic [DIV_DEN_W-1:0] DEN_VEL  = 20'd125;
  localparam logic [DIV_DEN_W-1:0] DEN_US   = 20'd1000000;
  localparam logic [DIV_NUM_W-1:0] HALF_VEL = 58'd62;
  localparam logic [DIV_NUM_W-1:0] HALF_US  = 58'd500000;

  // reciprocals floor(2^32 / divisor) for the digit estimate
  localparam logic [31:0] RCP_VEL = 32'((64'd1 << 32) / 64'd125);
  localparam logic [31:0] RCP_US  = 32'((64'd1 << 32) / 64'd1000000);

  // cordic constants, q4.30 in 34 bits
  localparam logic signed [33:0] COR_INIT = 34'sd652032874;
  localparam logic signed [33:0] COR_ONE  = 34'sd1073741824;
  localparam logic signed [33:0] COR_HALF = 34'sd2147483648;

  // heading scale 2^63 / (pi * 1e6) and its rounding offset
  localparam logic [41:0] HEAD_K   = 42'd2935890503282;
  localparam logic [79:0] HEAD_RND = 80'h8000_0000_0000;

  // controller states
  typedef enum logic [5:0] {
    ST_IDLE, ST_MUL_V, ST_DIV_V, ST_WAIT_V, ST_MUL_W, ST_DIV_W, ST_WAIT_W,
    ST_COR_P, ST_WAIT_P, ST_MUL_XC, ST_RND_X, ST_MD_X, ST_DIV_X, ST_WAIT_X,
    ST_MUL_YS, ST_RND_Y, ST_MD_Y, ST_DIV_Y, ST_WAIT_Y, ST_MUL_H, ST_SAVE_H,
    ST_P0, ST_A0, ST_P1, ST_A1, ST_P2, ST_A2, ST_P3, ST_A3, ST_HUPD,
    ST_COR_Q, ST_WAIT_Q, ST_OUT
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_MUL_V, OP_MUL_W, OP_DIV_V, OP_DIV_W, OP_SET_V, OP_SET_W,
    OP_COR_POSE, OP_SET_TRIG, OP_MUL_XC, OP_MUL_YS, OP_RND_M, OP_MUL_MD,
    OP_DIV_D, OP_SET_X, OP_SET_Y, OP_MUL_H, OP_SAVE_H, OP_MUL_P0, OP_MUL_P1,
    OP_MUL_P2, OP_MUL_P3, OP_ACC_LO, OP_ACC_MID, OP_ACC_HI, OP_HUPD,
    OP_COR_QUAT, OP_SET_QUAT, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic out_free;
  } stat_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [29:0] atan_bam(input logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/poi_div.sv */
// ----------------------------------------------------------------------------
// poi_div
// Unsigned divider for the two fixed divisors, one 12-bit quotient digit at a
// time: a reciprocal estimate, then one compare and subtract.
// ----------------------------------------------------------------------------
module poi_div import poi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  localparam int EXT_W = DIV_DIG_W * DIV_DIG_N;

  logic [EXT_W-1:0]     num_r, quot_r;
  logic [DIV_DEN_W-1:0] den_r, rem_r, rem_nxt;
  logic [31:0]          rcp_r, part_r, part, back, r0;
  logic [63:0]          prod;
  logic [DIV_DIG_W-1:0] est_r, qd;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 phase_r, busy_r, done_r;

  // digit estimate from the reciprocal, then remainder and correction
  always_comb begin
    part = {rem_r, num_r[EXT_W-1 -: DIV_DIG_W]};
    prod = 64'(part) * 64'(rcp_r);
    back = 32'(est_r) * 32'(den_r);
    r0   = part_r - back;
    if (r0 >= 32'(den_r)) begin
      qd      = est_r + 1'b1;
      rem_nxt = DIV_DEN_W'(r0 - 32'(den_r));
    end else begin
      qd      = est_r;
      rem_nxt = r0[DIV_DEN_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CNT_W'(DIV_DIG_N - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= EXT_W'(num);
      den_r  <= den;
      rcp_r  <= (den == DEN_US) ? RCP_US : RCP_VEL;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        part_r <= part;
        est_r  <= prod[32 +: DIV_DIG_W];
        num_r  <= {num_r[EXT_W-DIV_DIG_W-1:0], {DIV_DIG_W{1'b0}}};
      end else begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[EXT_W-DIV_DIG_W-1:0], qd};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r[DIV_NUM_W-1:0];

endmodule

/* rtl/poi_cordic.sv */
// ----------------------------------------------------------------------------
// poi_cordic
// Rotation-mode cordic, one micro-rotation per cycle, sine and cosine in q2.30.
// ----------------------------------------------------------------------------
module poi_cordic import poi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [33:0] x_r, y_r, z_r;
  logic signed [33:0] z0, xs, ys, at, xc, yc;
  logic               flip_r, flip0, busy_r, done_r;
  logic [CNT_W-1:0]   cnt_r;

  // fold the start angle into a quarter turn either side
  always_comb begin
    z0    = {{2{angle[31]}}, angle};
    flip0 = 1'b0;
    if (z0 > COR_ONE) begin
      z0    = z0 - COR_HALF;
      flip0 = 1'b1;
    end else if (z0 < -COR_ONE) begin
      z0    = z0 + COR_HALF;
      flip0 = 1'b1;
    end
  end

  // shifted terms of this step
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = {4'b0, atan_bam(5'(cnt_r))};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // micro-rotations
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= COR_INIT;
      y_r    <= '0;
      z_r    <= z0;
      flip_r <= flip0;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  // clamp to unit range and undo the fold
  always_comb begin
    xc = (x_r > COR_ONE) ? COR_ONE : ((x_r < -COR_ONE) ? -COR_ONE : x_r);
    yc = (y_r > COR_ONE) ? COR_ONE : ((y_r < -COR_ONE) ? -COR_ONE : y_r);
    if (flip_r) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign cos_o = xc[31:0];
  assign sin_o = yc[31:0];
  assign done  = done_r;

endmodule

/* rtl/poi_dp.sv */
// ----------------------------------------------------------------------------
// poi_dp
// Datapath: pose state, shared multiplier, divider, cordic and output register.
// ----------------------------------------------------------------------------
module poi_dp import poi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [15:0]    in_speed_raw,
  input  logic signed [15:0]    in_turn_raw,
  input  logic [31:0]           in_stamp_us,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic [31:0]           out_heading,
  output logic signed [31:0]    out_vel_forward,
  output logic signed [31:0]    out_vel_yaw,
  output logic signed [15:0]    out_quat_z,
  output logic signed [15:0]    out_quat_w
);

  // state and working registers
  logic signed [15:0] spd_gain_r, trn_gain_r, spd_r, trn_r;
  logic [31:0]        dt_r, prev_r, acc_h_r;
  logic               seen_r, neg_r, out_valid_r;
  logic signed [31:0] acc_x_r, acc_y_r, sn_r, cs_r;
  logic signed [25:0] v_r, w_r, m_r;
  logic signed [65:0] prod_r, prod_nxt;
  logic [56:0]        mag_r;
  logic [79:0]        hacc_r;
  logic signed [15:0] qz_r, qw_r;

  // output register
  logic signed [31:0] o_x_r, o_y_r, o_vf_r, o_vy_r;
  logic [31:0]        o_h_r;
  logic signed [15:0] o_qz_r, o_qw_r;

  // unit hookups
  logic                 div_start, div_done, cor_start, cor_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic [31:0]          cor_ang;
  logic signed [31:0]   cor_sin, cor_cos;

  // combinational helpers
  logic signed [32:0] mul_a, mul_b;
  logic               mul_en, div_neg;
  logic signed [33:0] nv;
  logic [33:0]        nv_abs;
  logic [65:0]        p_abs, m_rnd;
  logic [24:0]        w_abs;
  logic [63:0]        pp;
  logic signed [58:0] q_sig;
  logic signed [59:0] pos_sum;

  function automatic logic signed [31:0] sat32(input logic signed [59:0] s);
    logic signed [31:0] r;
    if (s > 60'sd2147483647)       r = 32'sh7fff_ffff;
    else if (s < -60'sd2147483648) r = 32'sh8000_0000;
    else                           r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rnd_q15(input logic signed [31:0] s);
    logic [31:0] a, r;
    a = s[31] ? 32'(-s) : 32'(s);
    r = (a + 32'd16384) >> 15;
    if (r > 32'd32767) r = 32'd32767;
    return s[31] ? -16'(r) : 16'(r);
  endfunction

  poi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  poi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cor_start),
    .angle(cor_ang),
    .done (cor_done),
    .sin_o(cor_sin),
    .cos_o(cor_cos)
  );

  // common arithmetic terms
  always_comb begin
    nv      = {prod_r[32:0], 1'b0};
    if (cmd.op == OP_DIV_W) nv = -nv;
    nv_abs  = nv[33] ? 34'(-nv) : 34'(nv);
    p_abs   = prod_r[65] ? 66'(-prod_r) : 66'(prod_r);
    m_rnd   = (p_abs + 66'd536870912) >> 30;
    w_abs   = w_r[25] ? 25'(-w_r) : w_r[24:0];
    pp      = prod_r[63:0];
    q_sig   = neg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    pos_sum = ((cmd.op == OP_SET_Y) ? 60'(acc_y_r) : 60'(acc_x_r)) + 60'(q_sig);
  end

  // operand selection for the multiplier, divider and cordic
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_VEL;
    div_neg   = 1'b0;
    cor_start = 1'b0;
    cor_ang   = acc_h_r;
    unique case (cmd.op)
      OP_MUL_V: begin
        mul_en = 1'b1; mul_a = 33'(spd_r); mul_b = 33'(spd_gain_r);
      end
      OP_MUL_W: begin
        mul_en = 1'b1; mul_a = 33'(trn_r); mul_b = 33'(trn_gain_r);
      end
      OP_MUL_XC: begin
        mul_en = 1'b1; mul_a = 33'(v_r); mul_b = 33'(cs_r);
      end
      OP_MUL_YS: begin
        mul_en = 1'b1; mul_a = 33'(v_r); mul_b = 33'(sn_r);
      end
      OP_MUL_MD: begin
        mul_en = 1'b1; mul_a = 33'(m_r); mul_b = $signed({1'b0, dt_r});
      end
      OP_MUL_H: begin
        mul_en = 1'b1; mul_a = $signed({8'b0, w_abs}); mul_b = $signed({1'b0, dt_r});
      end
      OP_MUL_P0: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, mag_r[31:0]});
        mul_b  = $signed({1'b0, HEAD_K[31:0]});
      end
      OP_MUL_P1: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, mag_r[31:0]});
        mul_b  = $signed({23'b0, HEAD_K[41:32]});
      end
      OP_MUL_P2: begin
        mul_en = 1'b1;
        mul_a  = $signed({8'b0, mag_r[56:32]});
        mul_b  = $signed({1'b0, HEAD_K[31:0]});
      end
      OP_MUL_P3: begin
        mul_en = 1'b1;
        mul_a  = $signed({8'b0, mag_r[56:32]});
        mul_b  = $signed({23'b0, HEAD_K[41:32]});
      end
      OP_DIV_V, OP_DIV_W: begin
        div_start = 1'b1;
        div_num   = 58'(nv_abs) + HALF_VEL;
        div_den   = DEN_VEL;
        div_neg   = nv[33];
      end
      OP_DIV_D: begin
        div_start = 1'b1;
        div_num   = p_abs[57:0] + HALF_US;
        div_den   = DEN_US;
        div_neg   = prod_r[65];
      end
      OP_COR_POSE: begin
        cor_start = 1'b1;
        cor_ang   = acc_h_r;
      end
      OP_COR_QUAT: begin
        cor_start = 1'b1;
        cor_ang   = {1'b0, acc_h_r[31:1]};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // configuration, pose state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_gain_r  <= GAIN_RESET;
      trn_gain_r  <= GAIN_RESET;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPEED_GAIN: spd_gain_r <= $signed(cfg_data);
          REG_TURN_GAIN:  trn_gain_r <= $signed(cfg_data);
          default:        spd_gain_r <= spd_gain_r;
        endcase
      end
      if (cmd.load) begin
        prev_r <= in_stamp_us;
        seen_r <= 1'b1;
      end
      if (cmd.op == OP_SET_X) acc_x_r <= sat32(pos_sum);
      if (cmd.op == OP_SET_Y) acc_y_r <= sat32(pos_sum);
      if (cmd.op == OP_HUPD) begin
        acc_h_r <= w_r[25] ? acc_h_r - hacc_r[79:48] : acc_h_r + hacc_r[79:48];
      end
      if (cmd.op == OP_OUT)  out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      spd_r <= in_speed_raw;
      trn_r <= in_turn_raw;
      dt_r  <= seen_r ? in_stamp_us - prev_r : 32'd0;
    end
    if (mul_en) prod_r <= prod_nxt;
    if (div_start) neg_r <= div_neg;
    unique case (cmd.op)
      OP_SET_V:    v_r    <= q_sig[25:0];
      OP_SET_W:    w_r    <= q_sig[25:0];
      OP_SET_TRIG: begin
        sn_r <= cor_sin;
        cs_r <= cor_cos;
      end
      OP_RND_M:    m_r    <= prod_r[65] ? -26'(m_rnd) : 26'(m_rnd);
      OP_SAVE_H:   mag_r  <= prod_r[56:0];
      OP_ACC_LO:   hacc_r <= HEAD_RND + {16'b0, pp};
      OP_ACC_MID:  hacc_r <= hacc_r + {pp[47:0], 32'b0};
      OP_ACC_HI:   hacc_r <= hacc_r + {pp[15:0], 64'b0};
      OP_SET_QUAT: begin
        qz_r <= rnd_q15(cor_sin);
        qw_r <= rnd_q15(cor_cos);
      end
      OP_OUT: begin
        o_x_r  <= acc_x_r;
        o_y_r  <= acc_y_r;
        o_h_r  <= acc_h_r;
        o_vf_r <= 32'(v_r);
        o_vy_r <= 32'(w_r);
        o_qz_r <= qz_r;
        o_qw_r <= qw_r;
      end
      default: begin
      end
    endcase
  end

  assign stat.div_done = div_done;
  assign stat.cor_done = cor_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_pos_x       = o_x_r;
  assign out_pos_y       = o_y_r;
  assign out_heading     = o_h_r;
  assign out_vel_forward = o_vf_r;
  assign out_vel_yaw     = o_vy_r;
  assign out_quat_z      = o_qz_r;
  assign out_quat_w      = o_qw_r;

endmodule

/* rtl/poi_ctrl.sv */
// ----------------------------------------------------------------------------
// poi_ctrl
// Sequencer that steps the datapath through one odometry update per item.
// ----------------------------------------------------------------------------
module poi_ctrl import poi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_V;
      ST_MUL_V:  state_nxt = ST_DIV_V;
      ST_DIV_V:  state_nxt = ST_WAIT_V;
      ST_WAIT_V: if (stat.div_done) state_nxt = ST_MUL_W;
      ST_MUL_W:  state_nxt = ST_DIV_W;
      ST_DIV_W:  state_nxt = ST_WAIT_W;
      ST_WAIT_W: if (stat.div_done) state_nxt = ST_COR_P;
      ST_COR_P:  state_nxt = ST_WAIT_P;
      ST_WAIT_P: if (stat.cor_done) state_nxt = ST_MUL_XC;
      ST_MUL_XC: state_nxt = ST_RND_X;
      ST_RND_X:  state_nxt = ST_MD_X;
      ST_MD_X:   state_nxt = ST_DIV_X;
      ST_DIV_X:  state_nxt = ST_WAIT_X;
      ST_WAIT_X: if (stat.div_done) state_nxt = ST_MUL_YS;
      ST_MUL_YS: state_nxt = ST_RND_Y;
      ST_RND_Y:  state_nxt = ST_MD_Y;
      ST_MD_Y:   state_nxt = ST_DIV_Y;
      ST_DIV_Y:  state_nxt = ST_WAIT_Y;
      ST_WAIT_Y: if (stat.div_done) state_nxt = ST_MUL_H;
      ST_MUL_H:  state_nxt = ST_SAVE_H;
      ST_SAVE_H: state_nxt = ST_P0;
      ST_P0:     state_nxt = ST_A0;
      ST_A0:     state_nxt = ST_P1;
      ST_P1:     state_nxt = ST_A1;
      ST_A1:     state_nxt = ST_P2;
      ST_P2:     state_nxt = ST_A2;
      ST_A2:     state_nxt = ST_P3;
      ST_P3:     state_nxt = ST_A3;
      ST_A3:     state_nxt = ST_HUPD;
      ST_HUPD:   state_nxt = ST_COR_Q;
      ST_COR_Q:  state_nxt = ST_WAIT_Q;
      ST_WAIT_Q: if (stat.cor_done) state_nxt = ST_OUT;
      ST_OUT:    if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.load = 1'b0;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_MUL_V:  cmd.op = OP_MUL_V;
      ST_DIV_V:  cmd.op = OP_DIV_V;
      ST_WAIT_V: cmd.op = stat.div_done ? OP_SET_V : OP_NONE;
      ST_MUL_W:  cmd.op = OP_MUL_W;
      ST_DIV_W:  cmd.op = OP_DIV_W;
      ST_WAIT_W: cmd.op = stat.div_done ? OP_SET_W : OP_NONE;
      ST_COR_P:  cmd.op = OP_COR_POSE;
      ST_WAIT_P: cmd.op = stat.cor_done ? OP_SET_TRIG : OP_NONE;
      ST_MUL_XC: cmd.op = OP_MUL_XC;
      ST_RND_X:  cmd.op = OP_RND_M;
      ST_MD_X:   cmd.op = OP_MUL_MD;
      ST_DIV_X:  cmd.op = OP_DIV_D;
      ST_WAIT_X: cmd.op = stat.div_done ? OP_SET_X : OP_NONE;
      ST_MUL_YS: cmd.op = OP_MUL_YS;
      ST_RND_Y:  cmd.op = OP_RND_M;
      ST_MD_Y:   cmd.op = OP_MUL_MD;
      ST_DIV_Y:  cmd.op = OP_DIV_D;
      ST_WAIT_Y: cmd.op = stat.div_done ? OP_SET_Y : OP_NONE;
      ST_MUL_H:  cmd.op = OP_MUL_H;
      ST_SAVE_H: cmd.op = OP_SAVE_H;
      ST_P0:     cmd.op = OP_MUL_P0;
      ST_A0:     cmd.op = OP_ACC_LO;
      ST_P1:     cmd.op = OP_MUL_P1;
      ST_A1:     cmd.op = OP_ACC_MID;
      ST_P2:     cmd.op = OP_MUL_P2;
      ST_A2:     cmd.op = OP_ACC_MID;
      ST_P3:     cmd.op = OP_MUL_P3;
      ST_A3:     cmd.op = OP_ACC_HI;
      ST_HUPD:   cmd.op = OP_HUPD;
      ST_COR_Q:  cmd.op = OP_COR_QUAT;
      ST_WAIT_Q: cmd.op = stat.cor_done ? OP_SET_QUAT : OP_NONE;
      ST_OUT:    cmd.op = stat.out_free ? OP_OUT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

/* rtl/planar_odometry_integrator_top.sv */
// Each accepted item runs four constant divisions, two cordic runs and the
// multiply and sequencing steps before out_valid rises. Items are handled
// one at a time: a new input is accepted only in the idle state, and the
// output step stalls while the previous result is still unread.
// Reset (synchronous, active low) zeroes the pose and the stamp history and
// sets both gains to 1.0.
// ----------------------------------------------------------------------------
// planar_odometry_integrator_top
// Dead-reckoning pose integrator for a unicycle platform.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_top import poi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_speed_raw,
  input  logic signed [15:0]    in_turn_raw,
  input  logic [31:0]           in_stamp_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_pos_x,
  output logic signed [31:0]    out_pos_y,
  output logic [31:0]           out_heading,
  output logic signed [31:0]    out_vel_forward,
  output logic signed [31:0]    out_vel_yaw,
  output logic signed [15:0]    out_quat_z,
  output logic signed [15:0]    out_quat_w
);

  cmd_t  cmd;
  stat_t stat;

  poi_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  poi_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_speed_raw   (in_speed_raw),
    .in_turn_raw    (in_turn_raw),
    .in_stamp_us    (in_stamp_us),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_heading    (out_heading),
    .out_vel_forward(out_vel_forward),
    .out_vel_yaw    (out_vel_yaw),
    .out_quat_z     (out_quat_z),
    .out_quat_w     (out_quat_w)
  );

  // an accepted item keeps the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // divider and cordic never finish together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.div_done && stat.cor_done))
    else $error("divider and cordic done together");

  // a result appears only from the output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == OP_OUT))
    else $error("result raised outside the output step");

endmodule
